// File: sv/awst_pkg.sv
// Shared constants for the altitude window statistics tracker.
package awst_pkg;

    // Field widths
    localparam int ALT_W       = 21;
    localparam int WLEN_W      = 7;
    localparam int HYST_W      = 17;
    localparam int TOT_OUT_W   = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Parameter defaults
    localparam int WINDOW_MAX_DEF = 64;
    localparam int TOTAL_BITS_DEF = 32;

    // Register reset values
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;
    localparam logic [HYST_W-1:0] HYST_RESET = 17'd300;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS    = 2'd1;

endpackage

// File: sv/awst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awst_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/awst_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module awst_div #(
    parameter int DVD_W = 27,
    parameter int DVS_W = 7,
    localparam int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    busy,
    output logic signed [DVD_W-1:0] quotient
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] mag_reg, mag_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] diff;
    logic             ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, mag_reg[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = ~diff[DVS_W+1];

    always_comb begin
        cnt_next = cnt_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        if (start) begin
            // Load magnitude and sign, clear the remainder
            cnt_next = CNT_W'(DVD_W);
            mag_next = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next = '0;
            dvs_next = divisor;
            neg_next = dividend[DVD_W-1];
        end else if (cnt_reg != '0) begin
            // Shift in one quotient bit
            cnt_next = cnt_reg - CNT_W'(1);
            mag_next = {mag_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? $signed(-mag_reg) : $signed(mag_reg);

endmodule

// File: sv/altitude_window_stats_tracker_unit.sv
// Altitude window statistics tracker: one sample in, mean, extremes and climb totals out.
// Each sample goes through the take, a ring read, the drop of the oldest sample and the
// append, then the climb test, which starts the restoring divider, the total update, the
// wait for the divider and the result load. The divider works out one quotient bit for
// each bit of the window sum (ALT_W + log2(WINDOW_MAX) bits) and runs on through the
// total update. s_ready is low while a sample is in progress. A finished result waits in
// the output register while the next sample is taken; the load of the following result
// stalls until that register is free. The configuration port is always ready, but
// writes belong in idle time, and a window_length write empties the window.
module altitude_window_stats_tracker_unit #(
    parameter int WINDOW_MAX = awst_pkg::WINDOW_MAX_DEF,
    parameter int TOTAL_BITS = awst_pkg::TOTAL_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [awst_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [awst_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Sample requests
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [awst_pkg::ALT_W-1:0]     s_altitude_cm,
    // Result requests
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [awst_pkg::ALT_W-1:0]     m_mean_cm,
    output logic signed [awst_pkg::ALT_W-1:0]     m_minimum_cm,
    output logic signed [awst_pkg::ALT_W-1:0]     m_maximum_cm,
    output logic [awst_pkg::TOT_OUT_W-1:0]        m_ascent_total_cm,
    output logic [awst_pkg::TOT_OUT_W-1:0]        m_descent_total_cm,
    output logic                                  m_minimum_changed,
    output logic                                  m_maximum_changed,
    output logic                                  m_ascent_changed,
    output logic                                  m_descent_changed
);

    localparam int ALT_W   = awst_pkg::ALT_W;
    localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = ALT_W + $clog2(WINDOW_MAX);
    localparam int CLAMP_W = (CNT_W > awst_pkg::WLEN_W) ? CNT_W : awst_pkg::WLEN_W;
    localparam int DEL_W   = ALT_W + 2;
    localparam int ADD_W   = ((TOTAL_BITS > ALT_W) ? TOTAL_BITS : ALT_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_DROP, ST_APPEND, ST_CLIMB, ST_TOTAL, ST_DIVIDE, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [awst_pkg::WLEN_W-1:0] wlen_reg, wlen_next;
    logic [awst_pkg::HYST_W-1:0] hyst_reg, hyst_next;

    logic signed [ALT_W-1:0] cur_reg, cur_next;
    logic                    full_reg, full_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ALT_W-1:0] lowest_reg, lowest_next;
    logic signed [ALT_W-1:0] highest_reg, highest_next;
    logic signed [ALT_W-1:0] ref_reg, ref_next;
    logic [TOTAL_BITS-1:0]   asc_reg, asc_next;
    logic [TOTAL_BITS-1:0]   des_reg, des_next;
    logic                    seen_reg, seen_next;
    logic                    asc_hit_reg, asc_hit_next;
    logic                    des_hit_reg, des_hit_next;
    logic [ALT_W-1:0]        amount_reg, amount_next;
    logic                    min_chg_reg, min_chg_next;
    logic                    max_chg_reg, max_chg_next;
    logic                    asc_chg_reg, asc_chg_next;
    logic                    des_chg_reg, des_chg_next;

    logic                           m_valid_reg, m_valid_next;
    logic signed [ALT_W-1:0]        m_mean_reg, m_mean_next;
    logic signed [ALT_W-1:0]        m_min_reg, m_min_next;
    logic signed [ALT_W-1:0]        m_max_reg, m_max_next;
    logic [awst_pkg::TOT_OUT_W-1:0] m_asc_reg, m_asc_next;
    logic [awst_pkg::TOT_OUT_W-1:0] m_des_reg, m_des_next;
    logic                           m_min_chg_reg, m_min_chg_next;
    logic                           m_max_chg_reg, m_max_chg_next;
    logic                           m_asc_chg_reg, m_asc_chg_next;
    logic                           m_des_chg_reg, m_des_chg_next;

    logic [CLAMP_W-1:0]      wlen_ext;
    logic [CNT_W-1:0]        len_eff;
    logic signed [CNT_W:0]   old_diff;
    logic [IDX_W-1:0]        oldest;
    logic signed [DEL_W-1:0] delta;
    logic signed [DEL_W-1:0] neg_delta;
    logic signed [DEL_W-1:0] hyst_s;
    logic [TOTAL_BITS-1:0]   acc_base;
    logic [ADD_W-1:0]        acc_sum;
    logic [ADD_W-1:0]        acc_limit;
    logic [TOTAL_BITS-1:0]   acc_new;

    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [ALT_W-1:0]        ram_rd_data;
    logic                    div_start;
    logic                    div_busy;
    logic signed [SUM_W-1:0] div_quot;

    // Sample ring
    awst_ram #(
        .WIDTH (ALT_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (cur_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (oldest),
        .rd_data (ram_rd_data)
    );

    // Mean divider
    awst_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (held_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Clamp the window length to 1..WINDOW_MAX
    assign wlen_ext = CLAMP_W'(wlen_reg);
    always_comb begin
        if (wlen_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (wlen_ext > CLAMP_W'(WINDOW_MAX)) begin
            len_eff = CNT_W'(WINDOW_MAX);
        end else begin
            len_eff = CNT_W'(wlen_ext);
        end
    end

    // Oldest slot: write slot minus samples held, wrapped round the ring
    assign old_diff = $signed({1'b0, CNT_W'(slot_reg)}) - $signed({1'b0, held_reg});
    assign oldest   = old_diff[CNT_W] ? IDX_W'(old_diff + (CNT_W + 1)'(WINDOW_MAX))
                                      : IDX_W'(old_diff);

    // Climb difference against the reference
    assign delta     = DEL_W'(cur_reg) - DEL_W'(ref_reg);
    assign neg_delta = -delta;
    assign hyst_s    = $signed(DEL_W'(hyst_reg));

    // Shared saturating adder for the ascent and descent totals
    assign acc_base  = asc_hit_reg ? asc_reg : des_reg;
    assign acc_sum   = ADD_W'(acc_base) + ADD_W'(amount_reg);
    assign acc_limit = ADD_W'({TOTAL_BITS{1'b1}});
    assign acc_new   = (acc_sum >= acc_limit) ? {TOTAL_BITS{1'b1}} : TOTAL_BITS'(acc_sum);

    assign ram_rd_en = (state_reg == ST_READ);
    assign ram_wr_en = (state_reg == ST_APPEND);
    assign div_start = (state_reg == ST_CLIMB);

    always_comb begin
        state_next     = state_reg;
        wlen_next      = wlen_reg;
        hyst_next      = hyst_reg;
        cur_next       = cur_reg;
        full_next      = full_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        ref_next       = ref_reg;
        asc_next       = asc_reg;
        des_next       = des_reg;
        seen_next      = seen_reg;
        asc_hit_next   = asc_hit_reg;
        des_hit_next   = des_hit_reg;
        amount_next    = amount_reg;
        min_chg_next   = min_chg_reg;
        max_chg_next   = max_chg_reg;
        asc_chg_next   = asc_chg_reg;
        des_chg_next   = des_chg_reg;
        m_valid_next   = m_valid_reg;
        m_mean_next    = m_mean_reg;
        m_min_next     = m_min_reg;
        m_max_next     = m_max_reg;
        m_asc_next     = m_asc_reg;
        m_des_next     = m_des_reg;
        m_min_chg_next = m_min_chg_reg;
        m_max_chg_next = m_max_chg_reg;
        m_asc_chg_next = m_asc_chg_reg;
        m_des_chg_next = m_des_chg_reg;

        // Drop a delivered result
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes; a window length write empties the window
        if (cfg_valid) begin
            case (cfg_index)
                awst_pkg::REG_WINDOW_LENGTH: begin
                    wlen_next = cfg_data[awst_pkg::WLEN_W-1:0];
                    slot_next = '0;
                    held_next = '0;
                    sum_next  = '0;
                end
                awst_pkg::REG_HYSTERESIS: begin
                    hyst_next = cfg_data[awst_pkg::HYST_W-1:0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                // Take a sample and note whether the window is full
                if (s_valid) begin
                    cur_next   = s_altitude_cm;
                    full_next  = (held_reg >= len_eff);
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DROP;
            end
            ST_DROP: begin
                // Remove the oldest sample from the sum when full
                if (full_reg) begin
                    sum_next = sum_reg - SUM_W'($signed(ram_rd_data));
                end
                state_next = ST_APPEND;
            end
            ST_APPEND: begin
                // Append the sample and advance the write slot
                sum_next  = sum_reg + SUM_W'(cur_reg);
                held_next = full_reg ? held_reg : held_reg + CNT_W'(1);
                slot_next = (slot_reg == IDX_W'(WINDOW_MAX - 1)) ? '0
                                                                 : slot_reg + IDX_W'(1);
                state_next = ST_CLIMB;
            end
            ST_CLIMB: begin
                asc_hit_next = 1'b0;
                des_hit_next = 1'b0;
                amount_next  = '0;
                if (!seen_reg) begin
                    // First sample sets extremes and reference, clears totals
                    lowest_next  = cur_reg;
                    highest_next = cur_reg;
                    ref_next     = cur_reg;
                    asc_next     = '0;
                    des_next     = '0;
                    seen_next    = 1'b1;
                    min_chg_next = 1'b1;
                    max_chg_next = 1'b1;
                    asc_chg_next = 1'b1;
                    des_chg_next = 1'b1;
                end else begin
                    min_chg_next = (cur_reg < lowest_reg);
                    max_chg_next = (cur_reg > highest_reg);
                    if (cur_reg < lowest_reg) begin
                        lowest_next = cur_reg;
                    end
                    if (cur_reg > highest_reg) begin
                        highest_next = cur_reg;
                    end
                    asc_chg_next = 1'b0;
                    des_chg_next = 1'b0;
                    // Hysteresis test; move the reference on a hit
                    if (delta > hyst_s) begin
                        asc_hit_next = 1'b1;
                        asc_chg_next = 1'b1;
                        amount_next  = delta[ALT_W-1:0];
                        ref_next     = cur_reg;
                    end else if (neg_delta > hyst_s) begin
                        des_hit_next = 1'b1;
                        des_chg_next = 1'b1;
                        amount_next  = neg_delta[ALT_W-1:0];
                        ref_next     = cur_reg;
                    end
                end
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                // Accumulate into the total that was hit
                if (asc_hit_reg) begin
                    asc_next = acc_new;
                end else if (des_hit_reg) begin
                    des_next = acc_new;
                end
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_mean_next    = div_quot[ALT_W-1:0];
                    m_min_next     = lowest_reg;
                    m_max_next     = highest_reg;
                    m_asc_next     = awst_pkg::TOT_OUT_W'(asc_reg);
                    m_des_next     = awst_pkg::TOT_OUT_W'(des_reg);
                    m_min_chg_next = min_chg_reg;
                    m_max_chg_next = max_chg_reg;
                    m_asc_chg_next = asc_chg_reg;
                    m_des_chg_next = des_chg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= awst_pkg::WLEN_RESET;
            hyst_reg    <= awst_pkg::HYST_RESET;
            slot_reg    <= '0;
            held_reg    <= '0;
            sum_reg     <= '0;
            lowest_reg  <= '0;
            highest_reg <= '0;
            ref_reg     <= '0;
            asc_reg     <= '0;
            des_reg     <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wlen_reg    <= wlen_next;
            hyst_reg    <= hyst_next;
            slot_reg    <= slot_next;
            held_reg    <= held_next;
            sum_reg     <= sum_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            ref_reg     <= ref_next;
            asc_reg     <= asc_next;
            des_reg     <= des_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg       <= cur_next;
        full_reg      <= full_next;
        asc_hit_reg   <= asc_hit_next;
        des_hit_reg   <= des_hit_next;
        amount_reg    <= amount_next;
        min_chg_reg   <= min_chg_next;
        max_chg_reg   <= max_chg_next;
        asc_chg_reg   <= asc_chg_next;
        des_chg_reg   <= des_chg_next;
        m_mean_reg    <= m_mean_next;
        m_min_reg     <= m_min_next;
        m_max_reg     <= m_max_next;
        m_asc_reg     <= m_asc_next;
        m_des_reg     <= m_des_next;
        m_min_chg_reg <= m_min_chg_next;
        m_max_chg_reg <= m_max_chg_next;
        m_asc_chg_reg <= m_asc_chg_next;
        m_des_chg_reg <= m_des_chg_next;
    end

    assign cfg_ready          = 1'b1;
    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_mean_cm          = m_mean_reg;
    assign m_minimum_cm       = m_min_reg;
    assign m_maximum_cm       = m_max_reg;
    assign m_ascent_total_cm  = m_asc_reg;
    assign m_descent_total_cm = m_des_reg;
    assign m_minimum_changed  = m_min_chg_reg;
    assign m_maximum_changed  = m_max_chg_reg;
    assign m_ascent_changed   = m_asc_chg_reg;
    assign m_descent_changed  = m_des_chg_reg;

endmodule
